>>> rtl/core/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg: shared types and constants of the two-class priority queue
// Opcodes, status codes, sequencer states and the stored slot word.
// ----------------------------------------------------------------------------
package tcpq_pkg;

   // Default number of queue slots
   localparam int unsigned DEFAULT_DEPTH = 16;

   // Field widths of the channel words
   localparam int unsigned OP_W    = 2;
   localparam int unsigned ID_W    = 16;
   localparam int unsigned AGE_W   = 8;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned COUNT_W = 5;

   // Reset value of the preferential age threshold
   localparam logic [AGE_W-1:0] PREF_AGE_RESET = AGE_W'(60);

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_SERVE    = 2'd1,
      OP_WITHDRAW = 2'd2,
      OP_QUERY    = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_DUP  = 2'd1,
      STAT_MISS = 2'd2,
      STAT_FULL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CK,
      S_ABSENT,
      S_MOVE_RD,
      S_MOVE_WR,
      S_PUT,
      S_RESP
   } state_type;

   // One queue slot as held in the slot memory
   typedef struct packed {
      logic [ID_W-1:0]  key;
      logic [AGE_W-1:0] age;
   } slot_type;

endpackage

>>> rtl/core/tcpq_if.sv
// ----------------------------------------------------------------------------
// tcpq_if: request and response channels of the two-class priority queue
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tcpq_req_if
   import tcpq_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [ID_W-1:0]    entry_id;
   logic [AGE_W-1:0]   entry_age;

   modport source (output valid, output operation, output entry_id, output entry_age,
                   input ready);
   modport sink   (input valid, input operation, input entry_id, input entry_age,
                   output ready);
endinterface

interface tcpq_rsp_if
   import tcpq_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [ID_W-1:0]    served_id;
   logic [AGE_W-1:0]   found_age;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, output status, output served_id, output found_age,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input served_id, input found_age,
                   input entry_count, output ready);
endinterface

>>> rtl/core/two_class_priority_queue_top.sv
// ----------------------------------------------------------------------------
// two_class_priority_queue_top: ordered queue of keyed entries, two classes
// Insert, serve head, withdraw by id and query age, one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request word (operation, entry_id, entry_age); rsp_ch
//   returns one response word (status, served_id, found_age, entry_count).
//   csr_we/csr_wdata write the preferential age threshold; write it only
//   while the queue is idle.
//   Entries live position-ordered in a single-port-write, registered-read slot
//   memory. One sequencer walks it a slot at a time: the key search reads and
//   then compares each slot examined, and every entry shifted by an insert or
//   removal is read, then written back one place over. req_ch is not ready
//   while a request is in progress; ready returns in the cycle after the
//   response is loaded into the output register.
//   Reset empties the queue and sets the threshold to 60; slot contents are
//   not cleared, and no sweep follows reset. If rsp_ch stalls, the response
//   word holds, and a following response waits in the sequencer until the
//   output register frees.
// ----------------------------------------------------------------------------
module two_class_priority_queue_top
   import tcpq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DEFAULT_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   tcpq_req_if.sink         req_ch,
   tcpq_rsp_if.source       rsp_ch,
   input  logic             csr_we,
   input  logic [AGE_W-1:0] csr_wdata
);

   localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   // Sequencer and request registers
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   op_type              op_ff, op_in;
   logic [ID_W-1:0]     key_ff, key_in;
   logic [AGE_W-1:0]    age_ff, age_in;
   logic [CNT_W-1:0]    held_ff, held_in;
   logic [CNT_W-1:0]    pref_ff, pref_in;
   logic [AGE_W-1:0]    pref_age_ff, pref_age_in;

   // Pending response fields
   status_type          res_status_ff, res_status_in;
   logic [ID_W-1:0]     res_served_ff, res_served_in;
   logic [AGE_W-1:0]    res_age_ff, res_age_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_served_ff, rsp_served_in;
   logic [AGE_W-1:0]    rsp_age_ff, rsp_age_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // Slot memory
   slot_type            slot_mem [QUEUE_DEPTH];
   slot_type            rd_q_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [IDX_W-1:0]    mem_raddr;
   slot_type            mem_wdata;

   logic [CNT_W-1:0]    idx_up;
   logic [CNT_W-1:0]    idx_dn;
   logic                is_pref;

   assign idx_up  = idx_ff + 1'b1;
   assign idx_dn  = idx_ff - 1'b1;
   assign is_pref = (age_ff >= pref_age_ff);

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.served_id   = rsp_served_ff;
   assign rsp_ch.found_age   = rsp_age_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

   // Write and read the slot memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_q_ff <= slot_mem[mem_raddr];
   end

   // Next state and datapath control
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      age_in        = age_ff;
      held_in       = held_ff;
      pref_in       = pref_ff;
      pref_age_in   = csr_we ? csr_wdata : pref_age_ff;
      res_status_in = res_status_ff;
      res_served_in = res_served_ff;
      res_age_in    = res_age_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_served_in = rsp_served_ff;
      rsp_age_in    = rsp_age_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[IDX_W-1:0];
      mem_raddr     = idx_ff[IDX_W-1:0];
      mem_wdata     = rd_q_ff;

      case (state_ff)
         // Take a request word and start the search, or skip it on an empty queue
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in         = op_type'(req_ch.operation);
               key_in        = req_ch.entry_id;
               age_in        = req_ch.entry_age;
               idx_in        = '0;
               res_status_in = STAT_OK;
               res_served_in = '0;
               res_age_in    = '0;
               state_in      = (held_ff == '0) ? S_ABSENT : S_SCAN_RD;
            end
         end
         // Fetch one slot
         S_SCAN_RD: begin
            state_in = S_SCAN_CK;
         end
         // Compare the fetched key; serve always hits the head
         S_SCAN_CK: begin
            if (rd_q_ff.key == key_ff || op_ff == OP_SERVE) begin
               pos_in = idx_ff;
               case (op_ff)
                  OP_INSERT: begin
                     res_status_in = STAT_DUP;
                     state_in      = S_RESP;
                  end
                  OP_QUERY: begin
                     res_age_in = rd_q_ff.age;
                     state_in   = S_RESP;
                  end
                  OP_SERVE: begin
                     res_served_in = rd_q_ff.key;
                     state_in      = S_MOVE_RD;
                  end
                  default: begin
                     state_in = S_MOVE_RD;
                  end
               endcase
            end else if (idx_up == held_ff) begin
               state_in = S_ABSENT;
            end else begin
               idx_in   = idx_up;
               state_in = S_SCAN_RD;
            end
         end
         // Key not held: place an insert if a slot is free, refuse everything else
         S_ABSENT: begin
            if (op_ff == OP_INSERT) begin
               if (held_ff == DEPTH_CNT) begin
                  res_status_in = STAT_FULL;
                  state_in      = S_RESP;
               end else begin
                  pos_in   = is_pref ? pref_ff : held_ff;
                  idx_in   = held_ff;
                  state_in = S_MOVE_RD;
               end
            end else begin
               res_status_in = STAT_MISS;
               state_in      = S_RESP;
            end
         end
         // Read the neighbor to shift, or finish the shift
         S_MOVE_RD: begin
            if (op_ff == OP_INSERT) begin
               if (idx_ff > pos_ff) begin
                  mem_raddr = idx_dn[IDX_W-1:0];
                  state_in  = S_MOVE_WR;
               end else begin
                  state_in = S_PUT;
               end
            end else begin
               if (idx_up < held_ff) begin
                  mem_raddr = idx_up[IDX_W-1:0];
                  state_in  = S_MOVE_WR;
               end else begin
                  held_in = held_ff - 1'b1;
                  if (pos_ff < pref_ff) begin
                     pref_in = pref_ff - 1'b1;
                  end
                  state_in = S_RESP;
               end
            end
         end
         // Write the neighbor one place over
         S_MOVE_WR: begin
            mem_we   = 1'b1;
            idx_in   = (op_ff == OP_INSERT) ? idx_dn : idx_up;
            state_in = S_MOVE_RD;
         end
         // Drop the new entry into its opened slot
         S_PUT: begin
            mem_we        = 1'b1;
            mem_waddr     = pos_ff[IDX_W-1:0];
            mem_wdata.key = key_ff;
            mem_wdata.age = age_ff;
            held_in       = held_ff + 1'b1;
            if (is_pref) begin
               pref_in = pref_ff + 1'b1;
            end
            state_in = S_RESP;
         end
         // Hand the response to the output register once it frees
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_served_in = res_served_ff;
               rsp_age_in    = res_age_ff;
               rsp_count_in  = COUNT_W'(held_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         pref_ff      <= '0;
         pref_age_ff  <= PREF_AGE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         pref_ff      <= pref_in;
         pref_age_ff  <= pref_age_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      age_ff        <= age_in;
      res_status_ff <= res_status_in;
      res_served_ff <= res_served_in;
      res_age_ff    <= res_age_in;
      rsp_status_ff <= rsp_status_in;
      rsp_served_ff <= rsp_served_in;
      rsp_age_ff    <= rsp_age_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // The queue never holds more than its slots
   assert property (@(posedge clock) disable iff (reset) held_ff <= DEPTH_CNT)
      else $error("held count exceeds queue depth");

   // Preferential entries are a prefix of the held entries
   assert property (@(posedge clock) disable iff (reset) pref_ff <= held_ff)
      else $error("preferred count exceeds held count");

   // A response waiting on a stalled output stays in the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && rsp_valid_ff && !rsp_ch.ready) |=> state_ff == S_RESP)
      else $error("response lost while output stalled");

   // The count moves by at most one per cycle
   assert property (@(posedge clock) disable iff (reset)
      (held_ff != $past(held_ff)) |->
         (held_ff == $past(held_ff) + 1'b1 || held_ff == $past(held_ff) - 1'b1))
      else $error("held count jumped");

endmodule
